// ===== src/differential_drive_pwm_limiter_assert.svh =====
`ifndef DIFFERENTIAL_DRIVE_PWM_LIMITER_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_PWM_LIMITER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DDPL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DDPL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ddpl_pkg.sv =====
package ddpl_pkg;

  localparam int FUNC_W        = 4;
  localparam int CMD_W         = 16;
  localparam int MAG_W         = 16;
  localparam int PROD_W        = 2 * MAG_W;
  localparam int CMP_W         = 10;
  localparam int APP_W         = 11;
  localparam int IN_DATA_W     = 56;
  localparam int OUT_DATA_W    = 48;
  localparam int SPEED_MAX_DEF = 1000;

  // floor(x * 3 / 5) and floor(x * 2 / 5) as reciprocal multiplies, exact for 16-bit x.
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = 18;
  localparam int RPROD_W     = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_35 = RECIP_W'(157287);
  localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'(104858);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_DRIVE        = 4'd0,
    FUNC_STOP         = 4'd1,
    FUNC_FORWARD      = 4'd2,
    FUNC_TURN_LEFT    = 4'd3,
    FUNC_TURN_RIGHT   = 4'd4,
    FUNC_SLIGHT_LEFT  = 4'd5,
    FUNC_SLIGHT_RIGHT = 4'd6,
    FUNC_SHARP_LEFT   = 4'd7,
    FUNC_SHARP_RIGHT  = 4'd8
  } func_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CMD_W-1:0]  left_cmd;
    logic [CMD_W-1:0]  right_cmd;
    logic [MAG_W-1:0]  speed;
    logic [MAG_W-1:0]  s35;
    logic [MAG_W-1:0]  s25;
  } cmd_t;

  typedef struct packed {
    logic             lneg;
    logic             rneg;
    logic [MAG_W-1:0] la;
    logic [MAG_W-1:0] ra;
    logic [MAG_W-1:0] ma;
    logic             scale;
  } mag_t;

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] rest;
  } dpair_t;

  typedef struct packed {
    logic             lneg;
    logic             rneg;
    logic [MAG_W-1:0] la;
    logic [MAG_W-1:0] ra;
    logic [MAG_W-1:0] dvs;
    logic             scale;
    dpair_t           l;
    dpair_t           r;
  } div_t;

  // One restoring step: shift the next dividend bit into the remainder and
  // the new quotient bit into the bottom of the dividend word.
  function automatic dpair_t div_step(dpair_t x, logic [MAG_W-1:0] dvs);
    logic [MAG_W:0] t;
    logic           ge;
    dpair_t         y;
    t      = {x.rem, x.rest[MAG_W-1]};
    ge     = (t >= {1'b0, dvs});
    y.rem  = ge ? MAG_W'(t - {1'b0, dvs}) : t[MAG_W-1:0];
    y.rest = {x.rest[MAG_W-2:0], ge};
    return y;
  endfunction

endpackage

// ===== src/differential_drive_pwm_limiter.sv =====
// Differential drive limiter: one drive command in, one wheel pair out.
// Input items arrive on the in_ stream: a mode code, a signed left/right pair
// for direct drive and a base speed for the preset turns. Each result item on
// the out_ stream carries both PWM compare values, the four bridge pin levels
// and the signed wheel speeds after proportional limiting to SPEED_MAX.
// The block is a 20-stage pipeline: a ratio stage, a decode/magnitude stage,
// a product stage, sixteen one-bit restoring division stages (one for each
// quotient bit, left and right wheel side by side) and the output register.
// One item is accepted per cycle indefinitely while out_tready stays
// high. Every stage carries its own valid bit. When the receiver stalls, the
// output register holds its item and stages behind it keep advancing into
// empty slots, so in_tready stays high until every stage holds an item.
// Reset (rst_n low at a rising edge) empties the pipeline; the held speeds
// exist only as the output register, and no item leaves before the first one
// is accepted. SPEED_MAX may be set from 2 to 65535; compares and speeds are
// truncated to their field widths when it is large.
`include "differential_drive_pwm_limiter_assert.svh"

module differential_drive_pwm_limiter #(
  parameter int SPEED_MAX = ddpl_pkg::SPEED_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // func[3:0], left_cmd[19:4], right_cmd[35:20], speed[51:36], zero fill above
  input  logic [ddpl_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // compare_left[9:0], compare_right[19:10], left_pin_one[20], left_pin_two[21],
  // right_pin_one[22], right_pin_two[23], applied_left[34:24],
  // applied_right[45:35], zero fill above
  output logic [ddpl_pkg::OUT_DATA_W-1:0] out_tdata
);

  import ddpl_pkg::*;

  localparam int DIV_STAGES = MAG_W;
  localparam int ST_A       = 0;
  localparam int ST_B       = 1;
  localparam int ST_D0      = 2;
  localparam int ST_DLAST   = ST_D0 + DIV_STAGES;
  localparam int ST_OUT     = ST_DLAST + 1;
  localparam int NS         = ST_OUT + 1;

  localparam logic [MAG_W-1:0] SM = MAG_W'(SPEED_MAX);

  // ---------------------------------------------------------------------------
  // Flow control. A stage may take a new item when it is empty or when some
  // stage downstream of it is empty, or when the output is being drained.
  // ---------------------------------------------------------------------------
  logic [NS-1:0] vld_r;
  logic [NS-1:0] adv;

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      adv[i] = out_tready ||
               ((vld_r | ((NS'(1) << i) - NS'(1))) != {NS{1'b1}});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  assign in_tready  = adv[ST_A];
  assign out_tvalid = vld_r[ST_OUT];

  // ---------------------------------------------------------------------------
  // Stage A: unpack and form speed*3/5 and speed*2/5 by reciprocal multiply.
  // ---------------------------------------------------------------------------
  cmd_t               a_r;
  cmd_t               a_nxt;
  logic [RPROD_W-1:0] p35;
  logic [RPROD_W-1:0] p25;

  always_comb begin
    a_nxt.func      = in_tdata[3:0];
    a_nxt.left_cmd  = in_tdata[19:4];
    a_nxt.right_cmd = in_tdata[35:20];
    a_nxt.speed     = in_tdata[51:36];
    p35             = RPROD_W'(a_nxt.speed) * RPROD_W'(RECIP_35);
    p25             = RPROD_W'(a_nxt.speed) * RPROD_W'(RECIP_25);
    a_nxt.s35       = p35[RECIP_SHIFT +: MAG_W];
    a_nxt.s25       = p25[RECIP_SHIFT +: MAG_W];
  end

  always_ff @(posedge clk) begin
    if (adv[ST_A]) begin
      a_r <= a_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: per-mode wheel magnitudes and signs, larger magnitude, limit test.
  // A negated base speed is negative only when the speed is nonzero.
  // ---------------------------------------------------------------------------
  mag_t b_r;
  mag_t b_nxt;
  logic sp_nz;

  always_comb begin
    sp_nz      = (a_r.speed != '0);
    b_nxt.lneg = 1'b0;
    b_nxt.rneg = 1'b0;
    b_nxt.la   = '0;
    b_nxt.ra   = '0;
    case (a_r.func)
      FUNC_DRIVE: begin
        b_nxt.lneg = a_r.left_cmd[CMD_W-1];
        b_nxt.rneg = a_r.right_cmd[CMD_W-1];
        b_nxt.la   = a_r.left_cmd[CMD_W-1] ? MAG_W'(~a_r.left_cmd + 16'd1) : a_r.left_cmd;
        b_nxt.ra   = a_r.right_cmd[CMD_W-1] ? MAG_W'(~a_r.right_cmd + 16'd1) : a_r.right_cmd;
      end
      FUNC_FORWARD: begin
        b_nxt.la = a_r.speed;
        b_nxt.ra = a_r.speed;
      end
      FUNC_TURN_LEFT: begin
        b_nxt.la   = a_r.s35;
        b_nxt.ra   = a_r.speed;
        b_nxt.rneg = sp_nz;
      end
      FUNC_TURN_RIGHT: begin
        b_nxt.la   = a_r.speed;
        b_nxt.lneg = sp_nz;
        b_nxt.ra   = a_r.s35;
      end
      FUNC_SLIGHT_LEFT: begin
        b_nxt.la = a_r.s25;
        b_nxt.ra = a_r.speed;
      end
      FUNC_SLIGHT_RIGHT: begin
        b_nxt.la = a_r.speed;
        b_nxt.ra = a_r.s25;
      end
      FUNC_SHARP_LEFT: begin
        b_nxt.la   = a_r.speed;
        b_nxt.lneg = sp_nz;
        b_nxt.ra   = a_r.speed;
      end
      FUNC_SHARP_RIGHT: begin
        b_nxt.la   = a_r.speed;
        b_nxt.ra   = a_r.speed;
        b_nxt.rneg = sp_nz;
      end
      default: begin
        // Stop, and every code without a meaning, leaves both wheels at rest.
        b_nxt.la = '0;
      end
    endcase
    b_nxt.ma    = (b_nxt.la > b_nxt.ra) ? b_nxt.la : b_nxt.ra;
    b_nxt.scale = (b_nxt.ma > SM);
  end

  always_ff @(posedge clk) begin
    if (adv[ST_B]) begin
      b_r <= b_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Division pipeline. Entry 0 holds the products magnitude*SPEED_MAX; since
  // the quotient never exceeds SPEED_MAX, the upper half is already below the
  // divisor and only sixteen quotient bits remain, one per stage.
  // ---------------------------------------------------------------------------
  div_t              div_r   [0:DIV_STAGES];
  div_t              div_nxt [1:DIV_STAGES];
  div_t              d0_nxt;
  logic [PROD_W-1:0] prod_l;
  logic [PROD_W-1:0] prod_r;

  always_comb begin
    prod_l       = PROD_W'(b_r.la) * PROD_W'(SM);
    prod_r       = PROD_W'(b_r.ra) * PROD_W'(SM);
    d0_nxt.lneg  = b_r.lneg;
    d0_nxt.rneg  = b_r.rneg;
    d0_nxt.la    = b_r.la;
    d0_nxt.ra    = b_r.ra;
    d0_nxt.dvs   = b_r.ma;
    d0_nxt.scale = b_r.scale;
    d0_nxt.l     = prod_l;
    d0_nxt.r     = prod_r;
  end

  always_comb begin
    for (int k = 1; k <= DIV_STAGES; k++) begin
      div_nxt[k]   = div_r[k-1];
      div_nxt[k].l = div_step(div_r[k-1].l, div_r[k-1].dvs);
      div_nxt[k].r = div_step(div_r[k-1].r, div_r[k-1].dvs);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_D0]) begin
      div_r[0] <= d0_nxt;
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (adv[ST_D0+k]) begin
        div_r[k] <= div_nxt[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: final magnitudes, compare values, pins, signed speeds.
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0] mag_l;
  logic [MAG_W-1:0] mag_r;
  logic [MAG_W-1:0] cmp_l;
  logic [MAG_W-1:0] cmp_r;
  logic [MAG_W-1:0] sgn_l;
  logic [MAG_W-1:0] sgn_r;
  logic [CMP_W-1:0] cmp_l_r;
  logic [CMP_W-1:0] cmp_l_nxt;
  logic [CMP_W-1:0] cmp_r_r;
  logic [CMP_W-1:0] cmp_r_nxt;
  logic             lneg_r;
  logic             rneg_r;
  logic [APP_W-1:0] app_l_r;
  logic [APP_W-1:0] app_l_nxt;
  logic [APP_W-1:0] app_r_r;
  logic [APP_W-1:0] app_r_nxt;

  always_comb begin
    mag_l     = div_r[DIV_STAGES].scale ? div_r[DIV_STAGES].l.rest : div_r[DIV_STAGES].la;
    mag_r     = div_r[DIV_STAGES].scale ? div_r[DIV_STAGES].r.rest : div_r[DIV_STAGES].ra;
    // A wheel at rest sits one count short of the period.
    cmp_l     = (mag_l == '0) ? (SM - MAG_W'(1)) : (SM - mag_l);
    cmp_r     = (mag_r == '0) ? (SM - MAG_W'(1)) : (SM - mag_r);
    sgn_l     = div_r[DIV_STAGES].lneg ? (~mag_l + MAG_W'(1)) : mag_l;
    sgn_r     = div_r[DIV_STAGES].rneg ? (~mag_r + MAG_W'(1)) : mag_r;
    cmp_l_nxt = cmp_l[CMP_W-1:0];
    cmp_r_nxt = cmp_r[CMP_W-1:0];
    app_l_nxt = sgn_l[APP_W-1:0];
    app_r_nxt = sgn_r[APP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      cmp_l_r <= cmp_l_nxt;
      cmp_r_r <= cmp_r_nxt;
      lneg_r  <= div_r[DIV_STAGES].lneg;
      rneg_r  <= div_r[DIV_STAGES].rneg;
      app_l_r <= app_l_nxt;
      app_r_r <= app_r_nxt;
    end
  end

  // The bridge polarity is mirrored between the two sides.
  assign out_tdata = {2'b00, app_r_r, app_l_r, rneg_r, ~rneg_r, ~lneg_r, lneg_r,
                      cmp_r_r, cmp_l_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `DDPL_ASSERT_NXT(a_accept_fills_first, in_tvalid && in_tready, vld_r[ST_A],
                   "accepted item did not enter the first stage")
  `DDPL_ASSERT_IMP(a_max_is_bound, vld_r[ST_B],
                   b_r.la <= b_r.ma && b_r.ra <= b_r.ma &&
                   (b_r.ma == b_r.la || b_r.ma == b_r.ra),
                   "larger magnitude does not bound both wheels")
  `DDPL_ASSERT_IMP(a_quot_in_range, vld_r[ST_DLAST] && div_r[DIV_STAGES].scale,
                   div_r[DIV_STAGES].l.rest <= SM && div_r[DIV_STAGES].r.rest <= SM,
                   "scaled magnitude exceeds the speed limit")
  `DDPL_ASSERT_IMP(a_rem_below_dvs, vld_r[ST_DLAST] && div_r[DIV_STAGES].scale,
                   div_r[DIV_STAGES].l.rem < div_r[DIV_STAGES].dvs &&
                   div_r[DIV_STAGES].r.rem < div_r[DIV_STAGES].dvs,
                   "division remainder not below divisor")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ddpl_pkg::*;

  // The block runs with its default speed limit, and the predictor uses the same value.
  localparam int SPEED_MAX = SPEED_MAX_DEF;
  // This many cycles passes after the last result before the final verdict.
  // It is well past the pipeline depth, so a late extra result would be seen.
  localparam int DRAIN_CYCLES = 40;
  // The receiver holds off once for this long. That is far more than the
  // pipeline depth, so the block fills up and lowers in_tready.
  localparam int LONG_HOLD = 80;
  // The run stops when no item moves on either channel for this many cycles.
  localparam int STALL_LIMIT = 2000;
  // Random idling stops once fewer than this many items remain on a channel.
  localparam int QUIET_TAIL = 60;
  localparam int RANDOM_ITEMS = 500;

  // One drive command, packed the way in_tdata carries it (func in the low bits).
  typedef struct packed {
    logic [MAG_W-1:0]  speed;
    logic [CMD_W-1:0]  right_cmd;
    logic [CMD_W-1:0]  left_cmd;
    logic [FUNC_W-1:0] func;
  } drive_cmd_t;

  // One wheel-pair result, packed the way out_tdata carries it.
  typedef struct packed {
    logic [APP_W-1:0] applied_right;
    logic [APP_W-1:0] applied_left;
    logic             right_pin_two;
    logic             right_pin_one;
    logic             left_pin_two;
    logic             left_pin_one;
    logic [CMP_W-1:0] compare_right;
    logic [CMP_W-1:0] compare_left;
  } wheel_out_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // func[3:0], left_cmd[19:4], right_cmd[35:20], speed[51:36], zero fill above
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // compare_left[9:0], compare_right[19:10], left_pin_one[20], left_pin_two[21],
  // right_pin_one[22], right_pin_two[23], applied_left[34:24],
  // applied_right[45:35], zero fill above
  logic [OUT_DATA_W-1:0] out_tdata;

  differential_drive_pwm_limiter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // Commands waiting to be offered, and the wheel results that the accepted
  // commands should produce, oldest first.
  drive_cmd_t pending_cmds[$];
  wheel_out_t wheel_expect_q[$];

  // The predictor's own copy of the held wheel speeds.
  logic [APP_W-1:0] held_left = '0;
  logic [APP_W-1:0] held_right = '0;

  int n_items = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_scaled = 0;
  int n_errors = 0;

  // PWM compare for a down-counting timer. A stopped wheel would be full
  // duty at max minus zero, so magnitude zero is moved to max minus one.
  function automatic logic [CMP_W-1:0] duty_compare(int mag);
    if (mag > SPEED_MAX) mag = SPEED_MAX;
    if (mag == 0) return CMP_W'(SPEED_MAX - 1);
    return CMP_W'(SPEED_MAX - mag);
  endfunction

  // Works out the wheel pair for one command and updates the held speeds.
  function automatic wheel_out_t limit_drive(drive_cmd_t c);
    int         base;
    int         vl;
    int         vr;
    int         la;
    int         ra;
    int         ma;
    logic       lneg;
    logic       rneg;
    wheel_out_t r;
    base = int'(c.speed);
    case (c.func)
      FUNC_DRIVE: begin
        vl = $signed(c.left_cmd);
        vr = $signed(c.right_cmd);
      end
      FUNC_FORWARD: begin
        vl = base;
        vr = base;
      end
      FUNC_TURN_LEFT: begin
        vl = base * 3 / 5;
        vr = -base;
      end
      FUNC_TURN_RIGHT: begin
        vl = -base;
        vr = base * 3 / 5;
      end
      FUNC_SLIGHT_LEFT: begin
        vl = base * 2 / 5;
        vr = base;
      end
      FUNC_SLIGHT_RIGHT: begin
        vl = base;
        vr = base * 2 / 5;
      end
      FUNC_SHARP_LEFT: begin
        vl = -base;
        vr = base;
      end
      FUNC_SHARP_RIGHT: begin
        vl = base;
        vr = -base;
      end
      // Stop and every unused code leave both wheels at rest.
      default: begin
        vl = 0;
        vr = 0;
      end
    endcase
    // The direction is taken before limiting, so a wheel scaled down to
    // zero still keeps the pin levels of its original sign.
    lneg = (vl < 0);
    rneg = (vr < 0);
    la = lneg ? -vl : vl;
    ra = rneg ? -vr : vr;
    ma = (la > ra) ? la : ra;
    if (ma > SPEED_MAX) begin
      la = int'(longint'(la) * SPEED_MAX / ma);
      ra = int'(longint'(ra) * SPEED_MAX / ma);
      n_scaled++;
    end
    held_left = APP_W'(lneg ? -la : la);
    held_right = APP_W'(rneg ? -ra : ra);
    r.compare_left = duty_compare(la);
    r.compare_right = duty_compare(ra);
    // The bridge pins are wired mirror-image on the two sides.
    r.left_pin_one = lneg;
    r.left_pin_two = !lneg;
    r.right_pin_one = !rneg;
    r.right_pin_two = rneg;
    r.applied_left = held_left;
    r.applied_right = held_right;
    return r;
  endfunction

  function automatic void check_field(string name, int expv, int actv);
    if (expv != actv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      n_errors++;
    end
  endfunction

  task automatic queue_cmd(func_t f, int lc, int rc, int sp);
    drive_cmd_t c;
    c.func = f;
    c.left_cmd = CMD_W'(lc);
    c.right_cmd = CMD_W'(rc);
    c.speed = MAG_W'(sp);
    pending_cmds.push_back(c);
  endtask

  // Random 16-bit field value. Half the picks are either near the limit or at a
  // boundary, since the interesting scaling decisions happen there; the
  // rest span the full field.
  function automatic logic [15:0] pick_value(bit is_cmd);
    case ($urandom_range(0, 3))
      0: return is_cmd ? 16'($urandom_range(0, 2200)) - 16'd1100
                       : 16'($urandom_range(0, 1700));
      1: begin
        case ($urandom_range(0, 7))
          0: return 16'h0000;
          1: return 16'h7FFF;
          2: return 16'h8000;
          3: return 16'hFFFF;
          4: return 16'd1000;
          5: return 16'd1001;
          6: return -16'sd1000;
          default: return -16'sd1001;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // Stimulus and the end of the run.
  initial begin
    drive_cmd_t c;
    int         r;

    // Direct drive: zero, the limit on both sides, just over it, the full
    // signed range, a wheel that scales down to zero but keeps its negative
    // sign, an in-range mixed pair and both wheels at the negative extreme.
    queue_cmd(FUNC_DRIVE, 0, 0, 0);
    queue_cmd(FUNC_DRIVE, 1000, -1000, 0);
    queue_cmd(FUNC_DRIVE, 1001, 0, 0);
    queue_cmd(FUNC_DRIVE, -32768, 32767, 0);
    queue_cmd(FUNC_DRIVE, 32767, -32768, 65535);
    queue_cmd(FUNC_DRIVE, -1, 32767, 0);
    queue_cmd(FUNC_DRIVE, 500, -250, 0);
    queue_cmd(FUNC_DRIVE, -32768, -32768, 0);
    // Straight ahead around the limit.
    queue_cmd(FUNC_FORWARD, 0, 0, 0);
    queue_cmd(FUNC_FORWARD, 0, 0, 1000);
    queue_cmd(FUNC_FORWARD, 0, 0, 1001);
    queue_cmd(FUNC_FORWARD, -1, -1, 65535);
    // Every preset turn at the largest speed, two tiny speeds whose reduced
    // wheel rounds down to zero, and a right turn at the limit.
    queue_cmd(FUNC_TURN_LEFT, 0, 0, 65535);
    queue_cmd(FUNC_TURN_RIGHT, 0, 0, 65535);
    queue_cmd(FUNC_SLIGHT_LEFT, 0, 0, 65535);
    queue_cmd(FUNC_SLIGHT_RIGHT, 0, 0, 65535);
    queue_cmd(FUNC_SHARP_LEFT, 0, 0, 65535);
    queue_cmd(FUNC_SHARP_RIGHT, 0, 0, 65535);
    queue_cmd(FUNC_TURN_LEFT, 0, 0, 1);
    queue_cmd(FUNC_SLIGHT_LEFT, 0, 0, 1);
    queue_cmd(FUNC_TURN_RIGHT, 0, 0, 1000);
    // Stop, and unused codes that must behave like stop whatever the other
    // fields say.
    queue_cmd(FUNC_STOP, -32768, 32767, 65535);
    queue_cmd(func_t'(9), 32767, -32768, 65535);
    queue_cmd(func_t'(12), 1000, 1000, 1000);
    queue_cmd(func_t'(15), -1, -1, 65535);

    // Random commands: mostly valid modes, with some stops and unused codes.
    repeat (RANDOM_ITEMS) begin
      r = $urandom_range(0, 19);
      c.func = (r < 17) ? FUNC_W'(r % 9) : FUNC_W'($urandom_range(9, 15));
      c.left_cmd = pick_value(1'b1);
      c.right_cmd = pick_value(1'b1);
      c.speed = pick_value(1'b0);
      pending_cmds.push_back(c);
    end
    n_items = pending_cmds.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Sampling on the falling edge keeps these checks clear of the updates
    // that the clocked blocks make at the rising edge.
    while (!(n_accepted == n_items && wheel_expect_q.size() == 0)) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (wheel_expect_q.size() != 0) begin
      $error("%0d expected result items never arrived", wheel_expect_q.size());
      n_errors++;
    end
    $display("Summary: %0d drive commands across all sixteen mode codes, %0d limited in proportion.",
             n_items, n_scaled);
    $display("Both channels idled in random bursts, and the receiver held off once for %0d cycles.",
             LONG_HOLD);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Driver. An offered item stays on the bus until it is accepted. After an
  // item goes out, a random gap may follow before the next one is offered.
  // The gap rate changes now and then, and it is zero at the start, so some
  // stretches have no idling at all.
  int in_gap = 0;
  int in_rate = 0;

  always @(posedge clk) begin : drive_proc
    logic       fire;
    drive_cmd_t next_cmd;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      fire = in_tvalid && in_tready;
      if (fire) begin
        wheel_expect_q.push_back(limit_drive(drive_cmd_t'(in_tdata[51:0])));
        n_accepted++;
      end
      if ($urandom_range(0, 49) == 0) in_rate = $urandom_range(0, 3);
      if (!in_tvalid || fire) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          next_cmd = pending_cmds.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= IN_DATA_W'(next_cmd);
          if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 9) < 2 * in_rate)
            in_gap = $urandom_range(1, 7);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every accepted result is compared field by field with the
  // oldest expectation. The ready line stalls in random bursts, and once,
  // after the first hundred results, it stays low for a long hold-off while
  // the driver keeps offering items.
  int  out_stall = 0;
  int  out_rate = 0;
  int  hold_left_cycles = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin : monitor_proc
    wheel_out_t got;
    wheel_out_t want;
    logic       ready_next;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = wheel_out_t'(out_tdata[45:0]);
        n_results++;
        if (wheel_expect_q.size() == 0) begin
          $error("result item arrived with no expected item waiting");
          n_errors++;
        end else begin
          want = wheel_expect_q.pop_front();
          check_field("compare_left", int'(want.compare_left), int'(got.compare_left));
          check_field("compare_right", int'(want.compare_right), int'(got.compare_right));
          check_field("left_pin_one", int'(want.left_pin_one), int'(got.left_pin_one));
          check_field("left_pin_two", int'(want.left_pin_two), int'(got.left_pin_two));
          check_field("right_pin_one", int'(want.right_pin_one), int'(got.right_pin_one));
          check_field("right_pin_two", int'(want.right_pin_two), int'(got.right_pin_two));
          check_field("applied_left", int'($signed(want.applied_left)),
                      int'($signed(got.applied_left)));
          check_field("applied_right", int'($signed(want.applied_right)),
                      int'($signed(got.applied_right)));
        end
      end
      if ($urandom_range(0, 49) == 0) out_rate = $urandom_range(0, 3);
      if (hold_left_cycles > 0) begin
        hold_left_cycles--;
        ready_next = 1'b0;
      end else if (!hold_done && n_results >= 100) begin
        hold_done = 1'b1;
        hold_left_cycles = LONG_HOLD - 1;
        ready_next = 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        ready_next = 1'b0;
      end else if (n_results + QUIET_TAIL < n_items &&
                   $urandom_range(0, 9) < 2 * out_rate) begin
        out_stall = $urandom_range(1, 7) - 1;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_tready <= ready_next;
    end
  end

  // Watchdog: counts cycles in which no item moves on either channel.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
